/* rtl/minmax_delta_byte_quantizer_top_macros.svh */
// Assertion macros shared by the quantizer RTL.
`ifndef MINMAX_DELTA_BYTE_QUANTIZER_TOP_MACROS_SVH
`define MINMAX_DELTA_BYTE_QUANTIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/mmdq_pkg.sv */
package mmdq_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int READ_SPAN      = 256;
  localparam int COORD_W        = 32;
  localparam int DELTA_W        = 33;
  localparam int AXES           = 3;
  localparam int Q_W            = 8;
  localparam int IDX_W          = 8;
  localparam int S_TDATA_W      = 200;
  localparam int S_TUSER_W      = 2;
  localparam int M_TDATA_W      = 224;
  localparam int M_TUSER_W      = 1;
  localparam int STORE_W        = AXES * DELTA_W;

  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [DELTA_W-1:0] span_t;

  localparam delta_t ACC_POS = 33'sh0_FFFF_FFFF;
  localparam delta_t ACC_NEG = 33'sh1_0000_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* rtl/mmdq_ram.sv */
module mmdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mmdq_div.sv */
`include "minmax_delta_byte_quantizer_top_macros.svh"

module mmdq_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  mmdq_pkg::span_t           offset,
  input  mmdq_pkg::span_t           divisor,
  output logic [mmdq_pkg::Q_W-1:0]  quotient,
  output mmdq_pkg::div_status_t     status
);
  import mmdq_pkg::*;

  localparam int NUM_W  = DELTA_W + Q_W;
  localparam int STEP_W = $clog2(Q_W);

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              ge;

  assign ge            = (rem >= dsh);
  assign status.busy   = busy;
  assign status.done   = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == '0);
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(Q_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // offset * 255 as (offset << 8) - offset, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {offset, {Q_W{1'b0}}} - NUM_W'(offset);
      dsh      <= NUM_W'({divisor, {(Q_W-1){1'b0}}});
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[Q_W-2:0], ge};
      dsh      <= dsh >> 1;
    end
  end

  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `ASSERT_IMPLY(a_no_restart, clk, rst, busy, !start)

endmodule

/* rtl/minmax_delta_byte_quantizer_top.sv */
// Loads: accept, then store write and bound update.
// Reads: accept, then one store read, then per axis a setup step and a wait on the
// single shared restoring divider (8 quotient bits), then one output step that
// stalls on a full output; a new item is accepted once the block is back in idle.
// A finished result may still wait in the output register meanwhile.
// rst (synchronous) empties the point set and resets the running bounds.
`include "minmax_delta_byte_quantizer_top_macros.svh"

module minmax_delta_byte_quantizer_top #(
  parameter int MAX_POINTS = mmdq_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // src_x, src_y, src_z, tgt_x, tgt_y, tgt_z, point_index
  input  logic [mmdq_pkg::S_TDATA_W-1:0]  s_tdata,
  // op, first
  input  logic [mmdq_pkg::S_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // quant_x, quant_y, quant_z, bound_min_x, bound_min_y, bound_min_z,
  // span_x, span_y, span_z, zero fill
  output logic [mmdq_pkg::M_TDATA_W-1:0]  m_tdata,
  // index_ok
  output logic [mmdq_pkg::M_TUSER_W-1:0]  m_tuser
);
  import mmdq_pkg::*;

  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int STORE_DEPTH = (MAX_POINTS < READ_SPAN) ? MAX_POINTS : READ_SPAN;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_SETUP,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  delta_t             run_min [AXES];
  delta_t             run_max [AXES];
  delta_t             dreg    [AXES];
  delta_t             mn      [AXES];
  span_t              sp      [AXES];
  logic [Q_W-1:0]     qb      [AXES];
  logic               first_r;
  logic               ok_r;
  logic [1:0]         axis;
  logic               axis_zero;

  logic               op;
  logic               first;
  logic [COORD_W-1:0] src [AXES];
  logic [COORD_W-1:0] tgt [AXES];
  logic [IDX_W-1:0]   point_index;
  logic               accept;
  logic               ok_next;

  logic [CNT_W-1:0]   base_cnt;
  logic               load_ok;
  logic               store_we;
  delta_t             base_min [AXES];
  delta_t             base_max [AXES];
  logic [STORE_W-1:0] store_rdata;

  delta_t             d_sel;
  delta_t             mn_sel;
  span_t              sp_sel;
  logic [DELTA_W:0]   diff;
  logic               diff_neg;
  span_t              off;
  logic               div_start;
  logic [Q_W-1:0]     div_q;
  div_status_t        div_st;

  assign op          = s_tuser[0];
  assign first       = s_tuser[1];
  assign point_index = s_tdata[6*COORD_W +: IDX_W];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      src[i] = s_tdata[i*COORD_W +: COORD_W];
      tgt[i] = s_tdata[(AXES+i)*COORD_W +: COORD_W];
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign ok_next  = CMP_W'(point_index) < CMP_W'(count);

  assign base_cnt = first_r ? '0 : count;
  assign load_ok  = base_cnt < CNT_W'(MAX_POINTS);
  assign store_we = (state == ST_LOAD) && load_ok && (base_cnt < CNT_W'(STORE_DEPTH));

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      base_min[i] = first_r ? ACC_POS : run_min[i];
      base_max[i] = first_r ? ACC_NEG : run_max[i];
    end
  end

  mmdq_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (base_cnt[AW-1:0]),
    .wdata ({dreg[2], dreg[1], dreg[0]}),
    .raddr (point_index[AW-1:0]),
    .rdata (store_rdata)
  );

  assign d_sel     = dreg[axis];
  assign mn_sel    = mn[axis];
  assign sp_sel    = sp[axis];
  assign diff      = {d_sel[DELTA_W-1], d_sel} - {mn_sel[DELTA_W-1], mn_sel};
  assign diff_neg  = diff[DELTA_W];
  assign off       = diff_neg ? '0 : ((diff[DELTA_W-1:0] > sp_sel) ? sp_sel
                                                                   : diff[DELTA_W-1:0]);
  assign div_start = (state == ST_SETUP);

  mmdq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .offset   (off),
    .divisor  (sp_sel),
    .quotient (div_q),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      axis     <= '0;
      for (int i = 0; i < AXES; i++) begin
        run_min[i] <= ACC_POS;
        run_max[i] <= ACC_NEG;
      end
    end else begin
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (op == OP_LOAD) begin
              for (int i = 0; i < AXES; i++) begin
                dreg[i] <= {tgt[i][COORD_W-1], tgt[i]} - {src[i][COORD_W-1], src[i]};
              end
              first_r <= first;
              state   <= ST_LOAD;
            end else begin
              ok_r  <= ok_next;
              state <= ST_READ;
            end
          end
        end
        ST_LOAD: begin
          if (load_ok) begin
            count <= base_cnt + 1'b1;
            for (int i = 0; i < AXES; i++) begin
              run_min[i] <= (dreg[i] <= base_min[i]) ? dreg[i] : base_min[i];
              run_max[i] <= (dreg[i] >= base_max[i]) ? dreg[i] : base_max[i];
            end
          end
          state <= ST_IDLE;
        end
        ST_READ: begin
          for (int i = 0; i < AXES; i++) begin
            dreg[i] <= store_rdata[i*DELTA_W +: DELTA_W];
            if (count == '0) begin
              mn[i] <= '0;
              sp[i] <= '0;
            end else begin
              mn[i] <= run_min[i];
              sp[i] <= run_max[i] - run_min[i];
            end
          end
          axis  <= '0;
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          axis_zero <= !ok_r || (sp_sel == '0) || diff_neg;
          state     <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_st.done) begin
            qb[axis] <= axis_zero ? '0 : div_q;
            if (axis == 2'(AXES - 1)) begin
              state <= ST_FINISH;
            end else begin
              axis  <= axis + 1'b1;
              state <= ST_SETUP;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata    <= M_TDATA_W'({sp[2], sp[1], sp[0], mn[2], mn[1], mn[0],
                                      qb[2], qb[1], qb[0]});
            m_tuser[0] <= ok_r;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_setup_div_free, clk, rst, state == ST_SETUP, !div_st.busy)
  `ASSERT_IMPLY(a_done_in_wait, clk, rst, div_st.done, state == ST_WAIT)
  `ASSERT_IMPLY(a_count_range, clk, rst, 1'b1, count <= CNT_W'(MAX_POINTS))
  `ASSERT_IMPLY(a_bad_index_zero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[23:0] == 24'd0)
  `ASSERT_IMPLY(a_rise_from_finish, clk, rst, $rose(m_tvalid), $past(state == ST_FINISH))

endmodule

/* tb/sv/minmax_delta_byte_quantizer_top_tb.sv */
module minmax_delta_byte_quantizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 600;
  localparam int DIR_ROWS    = 23;

  typedef struct packed {
    logic        op;
    logic        first;
    logic [31:0] src_x;
    logic [31:0] src_y;
    logic [31:0] src_z;
    logic [31:0] tgt_x;
    logic [31:0] tgt_y;
    logic [31:0] tgt_z;
    logic [7:0]  point_index;
  } pt_item_t;

  typedef struct packed {
    logic [7:0]  quant_x;
    logic [7:0]  quant_y;
    logic [7:0]  quant_z;
    logic [32:0] bound_min_x;
    logic [32:0] bound_min_y;
    logic [32:0] bound_min_z;
    logic [32:0] span_x;
    logic [32:0] span_y;
    logic [32:0] span_z;
    logic        index_ok;
  } quant_res_t;

  typedef struct packed {
    pt_item_t   item;
    logic       typed;
    quant_res_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [S_TUSER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [M_TUSER_W-1:0]  m_tuser;

  longint     delta_mem [READ_SPAN][3];
  int         loaded_cnt;
  longint     axis_lo [3];
  longint     axis_hi [3];
  quant_res_t quant_pending [$];
  quant_res_t got_res;
  quant_res_t want_res;
  int         mismatches = 0;
  int         items_sent = 0;
  int         cycles = 0;
  int         send_pct = 35;
  int         recv_pct = 57;
  logic [2:0] flat_mask = '0;
  dir_row_t   dir_tbl [DIR_ROWS];

  minmax_delta_byte_quantizer_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic void clear_bounds();
    loaded_cnt = 0;
    for (int a = 0; a < 3; a++) begin
      axis_lo[a] = longint'(ACC_POS);
      axis_hi[a] = longint'(ACC_NEG);
    end
  endfunction

  function automatic logic [7:0] scale_byte(longint d, longint mn, longint sp);
    longint off;
    if (sp == 0 || d < mn) return 8'd0;
    off = d - mn;
    if (off > sp) off = sp;
    return 8'((off * 255) / sp);
  endfunction

  function automatic void predict_quantized(input pt_item_t it, output bit emits,
                                            output quant_res_t r);
    longint     d [3];
    longint     mn [3];
    longint     sp [3];
    logic [7:0] qb [3];
    bit         ok;
    emits = 1'b0;
    r = '0;
    if (it.op == OP_LOAD) begin
      if (it.first) clear_bounds();
      if (loaded_cnt >= MAX_POINTS_DEF) return;
      d[0] = longint'($signed(it.tgt_x)) - longint'($signed(it.src_x));
      d[1] = longint'($signed(it.tgt_y)) - longint'($signed(it.src_y));
      d[2] = longint'($signed(it.tgt_z)) - longint'($signed(it.src_z));
      for (int a = 0; a < 3; a++) begin
        delta_mem[loaded_cnt][a] = d[a];
        if (d[a] <= axis_lo[a]) axis_lo[a] = d[a];
        if (d[a] >= axis_hi[a]) axis_hi[a] = d[a];
      end
      loaded_cnt++;
      return;
    end
    ok = int'(it.point_index) < loaded_cnt;
    for (int a = 0; a < 3; a++) begin
      mn[a] = (loaded_cnt == 0) ? 0 : axis_lo[a];
      sp[a] = (loaded_cnt == 0) ? 0 : axis_hi[a] - axis_lo[a];
      qb[a] = ok ? scale_byte(delta_mem[it.point_index][a], mn[a], sp[a]) : 8'd0;
    end
    emits = 1'b1;
    r.quant_x     = qb[0];
    r.quant_y     = qb[1];
    r.quant_z     = qb[2];
    r.bound_min_x = 33'(mn[0]);
    r.bound_min_y = 33'(mn[1]);
    r.bound_min_z = 33'(mn[2]);
    r.span_x      = 33'(sp[0]);
    r.span_y      = 33'(sp[1]);
    r.span_z      = 33'(sp[2]);
    r.index_ok    = ok;
  endfunction

  function automatic pt_item_t ld(logic first, logic [31:0] sx, logic [31:0] sy,
                                  logic [31:0] sz, logic [31:0] tx, logic [31:0] ty,
                                  logic [31:0] tz);
    pt_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.first = first;
    it.src_x = sx;
    it.src_y = sy;
    it.src_z = sz;
    it.tgt_x = tx;
    it.tgt_y = ty;
    it.tgt_z = tz;
    return it;
  endfunction

  function automatic pt_item_t rd(logic [7:0] idx);
    pt_item_t it;
    it = '0;
    it.op = OP_READ;
    it.point_index = idx;
    return it;
  endfunction

  function automatic quant_res_t res(logic [7:0] q, logic [32:0] mn, logic [32:0] sp,
                                     logic ok);
    return '{q, q, q, mn, mn, mn, sp, sp, sp, ok};
  endfunction

  function automatic logic [31:0] rnd_coord(int mode);
    logic [31:0] v;
    v = $urandom;
    case (mode)
      1: return {{12{v[19]}}, v[19:0]};
      2: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return v;
        endcase
      end
      default: return v;
    endcase
  endfunction

  function automatic pt_item_t make_load(logic first, int mode);
    logic [31:0] s [3];
    logic [31:0] t [3];
    for (int a = 0; a < 3; a++) begin
      s[a] = rnd_coord(mode);
      t[a] = flat_mask[a] ? s[a] : rnd_coord(mode);
    end
    return ld(first, s[0], s[1], s[2], t[0], t[1], t[2]);
  endfunction

  function automatic pt_item_t make_read(logic [7:0] idx);
    pt_item_t it;
    it.op = OP_READ;
    it.first = 1'($urandom_range(1));
    it.src_x = $urandom;
    it.src_y = $urandom;
    it.src_z = $urandom;
    it.tgt_x = $urandom;
    it.tgt_y = $urandom;
    it.tgt_z = $urandom;
    it.point_index = idx;
    return it;
  endfunction

  function automatic logic [7:0] pick_index(bit noisy);
    int top;
    top = (loaded_cnt > READ_SPAN) ? READ_SPAN : loaded_cnt;
    if (top == 0 || (noisy && $urandom_range(4) == 0)) return 8'($urandom_range(255));
    return 8'($urandom_range(top - 1));
  endfunction

  function automatic void cmp_field(input string name, input longint unsigned want,
                                    input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_item(input pt_item_t it, input logic typed, input quant_res_t want);
    bit         emits;
    quant_res_t r;
    while ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.point_index, it.tgt_z, it.tgt_y, it.tgt_x,
                 it.src_z, it.src_y, it.src_x};
    s_tuser  <= {it.first, it.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_quantized(it, emits, r);
    if (emits) quant_pending.push_back(typed ? want : r);
  endtask

  task automatic run_set(input int n_ld, input int n_rd, input int mode, input bit noisy);
    logic first;
    flat_mask = (mode == 3) ? 3'($urandom_range(7)) : 3'b000;
    for (int i = 0; i < n_ld; i++) begin
      if (i == 0) first = !noisy || $urandom_range(5) != 0;
      else first = noisy && $urandom_range(39) == 0;
      push_item(make_load(first, mode), 1'b0, '0);
      if (noisy && $urandom_range(7) == 0) push_item(make_read(pick_index(noisy)), 1'b0, '0);
    end
    for (int i = 0; i < n_rd; i++) push_item(make_read(pick_index(noisy)), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.quant_x     = m_tdata[7:0];
      got_res.quant_y     = m_tdata[15:8];
      got_res.quant_z     = m_tdata[23:16];
      got_res.bound_min_x = m_tdata[56:24];
      got_res.bound_min_y = m_tdata[89:57];
      got_res.bound_min_z = m_tdata[122:90];
      got_res.span_x      = m_tdata[155:123];
      got_res.span_y      = m_tdata[188:156];
      got_res.span_z      = m_tdata[221:189];
      got_res.index_ok    = m_tuser[0];
      if (quant_pending.size() == 0) begin
        $error("unexpected item on output: 0x%0h", m_tdata);
        mismatches++;
      end else begin
        want_res = quant_pending.pop_front();
        cmp_field("quant_x", want_res.quant_x, got_res.quant_x);
        cmp_field("quant_y", want_res.quant_y, got_res.quant_y);
        cmp_field("quant_z", want_res.quant_z, got_res.quant_z);
        cmp_field("bound_min_x", want_res.bound_min_x, got_res.bound_min_x);
        cmp_field("bound_min_y", want_res.bound_min_y, got_res.bound_min_y);
        cmp_field("bound_min_z", want_res.bound_min_z, got_res.bound_min_z);
        cmp_field("span_x", want_res.span_x, got_res.span_x);
        cmp_field("span_y", want_res.span_y, got_res.span_y);
        cmp_field("span_z", want_res.span_z, got_res.span_z);
        cmp_field("index_ok", want_res.index_ok, got_res.index_ok);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int  base;
    int  done_rand;
    bit  full_done;
    full_done = 1'b0;
    clear_bounds();
    dir_tbl = '{
      '{rd(8'd0), 1'b1, res(8'd0, 33'd0, 33'd0, 1'b0)},
      '{rd(8'd255), 1'b1, res(8'd0, 33'd0, 33'd0, 1'b0)},
      '{ld(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0), 1'b0, '0},
      '{rd(8'd0), 1'b1, res(8'd0, 33'd0, 33'd0, 1'b1)},
      '{rd(8'd1), 1'b1, res(8'd0, 33'd0, 33'd0, 1'b0)},
      '{ld(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0},
      '{ld(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0},
      '{rd(8'd0), 1'b1, res(8'd255, 33'h1_0000_0001, 33'h1_FFFF_FFFE, 1'b1)},
      '{rd(8'd1), 1'b1, res(8'd0, 33'h1_0000_0001, 33'h1_FFFF_FFFE, 1'b1)},
      '{rd(8'd2), 1'b1, res(8'd0, 33'h1_0000_0001, 33'h1_FFFF_FFFE, 1'b0)},
      '{ld(1'b0, 32'd1, 32'hFFFF_FFFF, 32'h1234_5678, 32'd3, 32'd0, 32'h1234_5678),
        1'b0, '0},
      '{rd(8'd2), 1'b0, '0},
      '{rd(8'd0), 1'b0, '0},
      '{ld(1'b1, 32'd0, 32'd0, 32'd0, 32'd5, 32'hFFFF_FFF9, 32'd0), 1'b0, '0},
      '{ld(1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd100, 32'd0), 1'b0, '0},
      '{ld(1'b0, 32'h0001_0000, 32'd0, 32'd0, 32'h0003_0000, 32'h8000_0000, 32'd7),
        1'b0, '0},
      '{rd(8'd0), 1'b0, '0},
      '{rd(8'd1), 1'b0, '0},
      '{rd(8'd2), 1'b0, '0},
      '{rd(8'hFF), 1'b0, '0},
      '{ld(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0,
           32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0},
      '{rd(8'd0), 1'b0, '0},
      '{rd(8'd1), 1'b0, '0}
    };
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) push_item(dir_tbl[i].item, dir_tbl[i].typed,
                                                 dir_tbl[i].want);
    base = items_sent;
    while (items_sent - base < RAND_ITEMS) begin
      done_rand = items_sent - base;
      if (done_rand >= 260 && !full_done) begin
        send_pct = 0;
        recv_pct = 0;
        full_done = 1'b1;
        // fill the store past capacity, then read anywhere in it
        run_set(MAX_POINTS_DEF + 6, 10, 0, 1'b0);
      end else begin
        if (done_rand >= 130 && done_rand < 260) begin
          send_pct = 57;
          recv_pct = 35;
        end
        run_set(($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12),
                $urandom_range(1, 6), $urandom_range(3), 1'b1);
      end
    end
    s_tvalid <= 1'b0;
    while (quant_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* minmax_delta_byte_quantizer_top.f */
+incdir+rtl
rtl/mmdq_pkg.sv
rtl/mmdq_ram.sv
rtl/mmdq_div.sv
rtl/minmax_delta_byte_quantizer_top.sv
tb/sv/minmax_delta_byte_quantizer_top_tb.sv
